### rtl/core/css_pkg.sv
// Shared types, constants and the case-fold function for the caseless substring search.
// Used by caseless_substring_search, css_match and css_checker; depends on nothing.
package css_pkg;

	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 4;
	localparam int POS_W      = 32;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 1;

	typedef logic [BYTE_W-1:0]     byte_t;
	typedef logic [LEN_W-1:0]      len_t;
	typedef logic [POS_W-1:0]      pos_t;
	typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	// Register map of the configuration port
	localparam cfg_addr_t REG_PATTERN_BYTES  = 1'b0;
	localparam cfg_addr_t REG_PATTERN_LENGTH = 1'b1;

	// Saturated byte position
	localparam pos_t POS_SAT = '1;

	// One result item
	typedef struct packed {
		logic found;
		pos_t start;
	} result_t;

	// Fold ASCII lower case letters to upper case, leave every other byte alone
	function automatic byte_t fold_case(input byte_t c);
		byte_t r;
		r = c;
		if (c inside {[8'h61:8'h7a]}) begin
			r = c & 8'hdf;
		end
		return r;
	endfunction

endpackage

### rtl/core/css_match.sv
// Parallel comparator bank: tests the updated text window against the folded pattern.
// Depends on css_pkg (types, fold_case).
module css_match #(
	parameter int PATTERN_MAX = 8
) (
	input  logic [PATTERN_MAX-1:0][css_pkg::BYTE_W-1:0] window,
	input  css_pkg::cfg_data_t                          pattern,
	input  css_pkg::len_t                               len,
	output logic                                        hit
);

	css_pkg::byte_t pat_fold [PATTERN_MAX];

	// Fold each pattern character once
	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			pat_fold[i] = css_pkg::fold_case(pattern[css_pkg::BYTE_W*i +: css_pkg::BYTE_W]);
		end
	end

	// One comparator row per candidate length; the active length picks its row.
	// Window entry zero is the newest byte, so the first pattern character
	// lines up with the oldest of the last len bytes.
	always_comb begin
		logic ok;
		hit = 1'b0;
		for (int l = 1; l <= PATTERN_MAX; l++) begin
			ok = 1'b1;
			for (int i = 0; i < l; i++) begin
				if (pat_fold[i] != window[l-1-i]) begin
					ok = 1'b0;
				end
			end
			if (len == css_pkg::LEN_W'(l) && ok) begin
				hit = 1'b1;
			end
		end
	end

endmodule

### rtl/core/caseless_substring_search.sv
// Top level of the caseless substring search: input stage, text window, result register.
// Depends on css_pkg and css_match.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+---------------------------------------
//   config   | cfg_wr_en                 | cfg_addr, cfg_wdata
//   input    | in_valid / in_ready       | text_byte, byte_present, text_end
//   result   | out_valid / out_ready     | found, match_start
//
// An item goes from its transfer into the input register, then through the window
// shift and comparator bank into the result register. A new item is taken every
// cycle while the result side keeps up.
// in_ready drops only while both the input register and an untaken result are held.
// Reset clears the pattern registers, the window, the position and the reported flag.
module caseless_substring_search #(
	parameter int PATTERN_MAX = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   cfg_wr_en,
	input  css_pkg::cfg_addr_t     cfg_addr,
	input  css_pkg::cfg_data_t     cfg_wdata,

	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             text_byte,
	input  logic                   byte_present,
	input  logic                   text_end,

	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   found,
	output logic [31:0]            match_start
);

	css_pkg::cfg_data_t pattern_bytes_q;
	css_pkg::len_t      pattern_length_q;

	logic               valid_s1;
	css_pkg::byte_t     text_byte_s1;
	logic               byte_present_s1;
	logic               text_end_s1;

	logic [PATTERN_MAX-1:0][css_pkg::BYTE_W-1:0] window_q;
	logic [PATTERN_MAX-1:0][css_pkg::BYTE_W-1:0] window_shift;
	css_pkg::pos_t      pos_q;
	logic               reported_q;

	logic               out_valid_q;
	css_pkg::result_t   result_q;

	logic               advance;
	css_pkg::len_t      len_used;
	css_pkg::len_t      len_m1;
	logic               pos_sat;
	logic               pos_ok;
	css_pkg::pos_t      pos_inc;
	logic               hit;
	logic               match;
	logic               empty_pat;
	logic               has_result;
	css_pkg::result_t   result_d;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bytes_q  <= '0;
			pattern_length_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				css_pkg::REG_PATTERN_BYTES:  pattern_bytes_q  <= cfg_wdata;
				css_pkg::REG_PATTERN_LENGTH: pattern_length_q <= cfg_wdata[css_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage one moves on when the result register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			text_byte_s1    <= text_byte;
			byte_present_s1 <= byte_present;
			text_end_s1     <= text_end;
		end
	end

	// Clamp the length and check that enough bytes have arrived
	assign len_used  = (pattern_length_q > css_pkg::LEN_W'(PATTERN_MAX))
	                 ? css_pkg::LEN_W'(PATTERN_MAX) : pattern_length_q;
	assign len_m1    = len_used - css_pkg::LEN_W'(1);
	assign empty_pat = (len_used == '0);
	assign pos_sat   = (pos_q == css_pkg::POS_SAT);
	assign pos_ok    = pos_sat || (pos_q >= css_pkg::POS_W'(len_m1));
	assign pos_inc   = pos_sat ? pos_q : pos_q + css_pkg::POS_W'(1);

	// Window after taking the folded byte, newest at entry zero
	always_comb begin
		window_shift[0] = css_pkg::fold_case(text_byte_s1);
		for (int i = 1; i < PATTERN_MAX; i++) begin
			window_shift[i] = window_q[i-1];
		end
	end

	css_match #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_match (
		.window  (window_shift),
		.pattern (pattern_bytes_q),
		.len     (len_used),
		.hit     (hit)
	);

	assign match = !empty_pat && byte_present_s1 && pos_ok && hit;

	// Form the result for this item
	always_comb begin
		has_result     = !reported_q && (empty_pat || match || text_end_s1);
		result_d.found = empty_pat || match;
		if (empty_pat || !match) begin
			result_d.start = '0;
		end else if (pos_sat) begin
			result_d.start = css_pkg::POS_SAT;
		end else begin
			result_d.start = pos_q - css_pkg::POS_W'(len_m1);
		end
	end

	// Text state: advance the window and position, clear at the end of a text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= '0;
			pos_q      <= '0;
			reported_q <= 1'b0;
		end else if (advance) begin
			if (text_end_s1) begin
				window_q   <= '0;
				pos_q      <= '0;
				reported_q <= 1'b0;
			end else if (!reported_q) begin
				if (empty_pat) begin
					reported_q <= 1'b1;
				end else if (byte_present_s1) begin
					window_q <= window_shift;
					pos_q    <= pos_inc;
					if (match) begin
						reported_q <= 1'b1;
					end
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= has_result;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			result_q <= result_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = result_q.found;
	assign match_start = result_q.start;

endmodule

### rtl/core/css_checker.sv
// Port-level checks for caseless_substring_search, attached by the bind below.
// Depends on css_pkg for widths.
module css_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic                found,
	input css_pkg::pos_t       match_start
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(match_start))
		else $error("result changed while stalled");

	// A miss always carries position zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_start == '0)
		else $error("miss with nonzero position");

	// Input stalls only behind an untaken result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

endmodule

bind caseless_substring_search css_checker u_css_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.found       (found),
	.match_start (match_start)
);
